[hw/rtl/deq_pkg.sv]
// Shared types and constants for the double-ended queue with search.
// No dependencies; every other file in hw/rtl uses this package.
`default_nettype none

package deq_pkg;

    // Fixed widths of the channel fields
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Operation codes carried in the kind field
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_QUERY      = 3'd4
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN
    } t_state;

    // Memory port strobes from the sequencer to the ring store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // Result load request from the sequencer to the output register
    typedef struct packed {
        logic    load;
        logic    use_rd;
        logic    found;
        t_status status;
    } t_rsp_ctl;

endpackage

`default_nettype wire

[hw/rtl/deq_in_if.sv]
// Input channel of the queue: valid/ready handshake with kind and value.
// Depends on deq_pkg for the field widths.
`default_nettype none

interface deq_in_if;

    logic                        valid;
    logic                        ready;
    logic [deq_pkg::KIND_W-1:0]  kind;
    logic [deq_pkg::VALUE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);

endinterface

`default_nettype wire

[hw/rtl/deq_out_if.sv]
// Result channel of the queue: valid/ready handshake with the result fields.
// Depends on deq_pkg for the field widths.
`default_nettype none

interface deq_out_if;

    logic                         valid;
    logic                         ready;
    logic [deq_pkg::VALUE_W-1:0]  popped_value;
    logic                         found;
    logic [deq_pkg::STATUS_W-1:0] status;
    logic [deq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output popped_value, output found, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input popped_value, input found, input status,
                    input occupancy, output ready);

endinterface

`default_nettype wire

[hw/rtl/deq_store.sv]
// Ring store of the queue: one write port, one read port with registered data.
// Depends on deq_pkg for the port strobe struct.
`default_nettype none

module deq_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int AW        = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  deq_pkg::t_mem_ctl     i_mem,
    input  logic [AW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Write the pushed element
    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        if (i_mem.rd_en) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hw/rtl/deq_ctrl.sv]
// Sequencer of the queue: head and count registers, the shared wrap adder,
// the single search comparator and the state machine. Depends on deq_pkg.
`default_nettype none

module deq_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [deq_pkg::KIND_W-1:0]  i_kind,
    input  logic [DATA_WIDTH-1:0]       i_value,
    input  logic                        i_out_free,
    input  logic [DATA_WIDTH-1:0]       i_rd_data,
    output deq_pkg::t_mem_ctl           o_mem,
    output logic [AW-1:0]               o_waddr,
    output logic [DATA_WIDTH-1:0]       o_wdata,
    output logic [AW-1:0]               o_raddr,
    output deq_pkg::t_rsp_ctl           o_rsp,
    output logic [CW-1:0]               o_count_next
);
    import deq_pkg::*;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_ptr, n_ptr;
    logic [AW-1:0]         r_left, n_left;
    logic [DATA_WIDTH-1:0] r_key;

    logic          accept;
    logic          full;
    logic          empty;
    logic          match;
    t_kind         kind;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] op_base;
    logic [CW-1:0] op_off;
    logic [CW:0]   sum_raw;
    logic [AW-1:0] sum_wrap;

    assign o_ready = (r_state == ST_IDLE) && i_out_free;
    assign accept  = i_valid && o_ready;
    assign kind    = t_kind'(i_kind);
    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign match   = (i_rd_data == r_key);
    assign o_wdata = i_value;

    // Step the head back one slot with wrap
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);

    // Select the operands of the shared wrap adder
    always_comb begin
        op_base = r_head;
        op_off  = CW'(1);
        if (r_state == ST_SCAN) begin
            op_base = r_ptr;
        end else begin
            case (kind)
                KIND_PUSH_BACK: op_off = r_count;
                KIND_POP_BACK:  op_off = r_count - CW'(1);
                default:        op_off = CW'(1);
            endcase
        end
    end

    // Add an offset to a ring slot and fold it back below the depth
    assign sum_raw  = {1'b0, CW'(op_base)} + {1'b0, op_off};
    assign sum_wrap = (sum_raw >= (CW + 1)'(DEPTH)) ? AW'(sum_raw - (CW + 1)'(DEPTH))
                                                    : AW'(sum_raw);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !empty) begin
                    if (kind == KIND_POP_FRONT || kind == KIND_POP_BACK) begin
                        n_state = ST_POP;
                    end else if (kind == KIND_QUERY) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_POP: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (match || r_left == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath controls and result requests
    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_left     = r_left;
        o_mem      = '0;
        o_waddr    = sum_wrap;
        o_raddr    = r_head;
        o_rsp      = '0;
        o_rsp.status = STATUS_OK;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (kind)
                        KIND_PUSH_FRONT: begin
                            o_rsp.load = 1'b1;
                            if (full) begin
                                o_rsp.status = STATUS_FULL;
                            end else begin
                                o_mem.wr_en = 1'b1;
                                o_waddr     = head_dec;
                                n_head      = head_dec;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        KIND_PUSH_BACK: begin
                            o_rsp.load = 1'b1;
                            if (full) begin
                                o_rsp.status = STATUS_FULL;
                            end else begin
                                o_mem.wr_en = 1'b1;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        KIND_POP_FRONT: begin
                            if (empty) begin
                                o_rsp.load   = 1'b1;
                                o_rsp.status = STATUS_EMPTY;
                            end else begin
                                o_mem.rd_en = 1'b1;
                                o_raddr     = r_head;
                                n_head      = sum_wrap;
                                n_count     = r_count - CW'(1);
                            end
                        end
                        KIND_POP_BACK: begin
                            if (empty) begin
                                o_rsp.load   = 1'b1;
                                o_rsp.status = STATUS_EMPTY;
                            end else begin
                                o_mem.rd_en = 1'b1;
                                o_raddr     = sum_wrap;
                                n_count     = r_count - CW'(1);
                            end
                        end
                        KIND_QUERY: begin
                            if (empty) begin
                                o_rsp.load   = 1'b1;
                                o_rsp.status = STATUS_EMPTY;
                            end else begin
                                o_mem.rd_en = 1'b1;
                                o_raddr     = r_head;
                                n_ptr       = sum_wrap;
                                n_left      = AW'(r_count - CW'(1));
                            end
                        end
                        default: begin
                            // unused codes do nothing but answer
                            o_rsp.load = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP: begin
                o_rsp.load   = 1'b1;
                o_rsp.use_rd = 1'b1;
            end
            ST_SCAN: begin
                if (match) begin
                    o_rsp.load  = 1'b1;
                    o_rsp.found = 1'b1;
                end else if (r_left == '0) begin
                    o_rsp.load = 1'b1;
                end else begin
                    o_mem.rd_en = 1'b1;
                    o_raddr     = r_ptr;
                    n_ptr       = sum_wrap;
                    n_left      = r_left - AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_count_next = n_count;

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_ptr   <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_ptr   <= n_ptr;
            r_left  <= n_left;
        end
    end

    // Hold the search key for the scan
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_value;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/double_ended_queue_with_search.sv]
// Top level of the double-ended queue with search: channels, result register.
// Depends on deq_pkg, deq_in_if, deq_out_if, deq_store and deq_ctrl.
`default_nettype none

// Bounded double-ended queue of DEPTH elements of DATA_WIDTH bits, held in a
// ring store with a head pointer and a count. Each input transfer carries one
// operation: push front, push back, pop front, pop back, or a membership
// query; each gives exactly one result transfer with the popped element, a
// found flag, a status (ok, empty, full) and the occupancy after the
// operation. Operations run one at a time and input ready is low while one
// is in progress. A push loads its result as it is accepted; a pop reads
// the element through the registered read port of the ring store and loads
// it in the pop state; a query reads the head and then scans k entries, where
// k is the number of entries compared before a match or the end of the
// queue (at most the occupancy), since the single comparator checks one
// entry per cycle as the scan walks the store's one read port. Errors and
// unused operation codes answer as they are accepted. A result waits in an
// output register, and the next operation is taken in the cycle that result transfers.

module double_ended_queue_with_search #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    deq_in_if.sink      i_in,
    deq_out_if.source   o_out
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                          ready;
    logic                          out_free;
    logic [DATA_WIDTH+VALUE_W-1:0] value_ext;
    logic [DATA_WIDTH-1:0]         in_data;
    logic [DATA_WIDTH-1:0]         rd_data;
    logic [DATA_WIDTH+VALUE_W-1:0] rd_ext;
    logic [CW-1:0]                 count_next;
    logic [CW+OCC_W-1:0]           count_ext;
    t_mem_ctl                      mem_ctl;
    t_rsp_ctl                      rsp;
    logic [AW-1:0]                 waddr;
    logic [AW-1:0]                 raddr;
    logic [DATA_WIDTH-1:0]         wdata;

    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_popped;
    logic                 r_found;
    t_status              r_status;
    logic [OCC_W-1:0]     r_occ;

    // Fit the value and result fields to the stored element width
    assign value_ext = {{DATA_WIDTH{1'b0}}, i_in.value};
    assign in_data   = value_ext[DATA_WIDTH-1:0];
    assign rd_ext    = {{VALUE_W{1'b0}}, rd_data};
    assign count_ext = {{OCC_W{1'b0}}, count_next};

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = ready;

    deq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (ready),
        .i_kind       (i_in.kind),
        .i_value      (in_data),
        .i_out_free   (out_free),
        .i_rd_data    (rd_data),
        .o_mem        (mem_ctl),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_raddr      (raddr),
        .o_rsp        (rsp),
        .o_count_next (count_next)
    );

    deq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_mem     (mem_ctl),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr   (raddr),
        .o_rd_data (rd_data)
    );

    // Hold the result until it transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp.load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture the result fields
    always_ff @(posedge i_clk) begin
        if (rsp.load) begin
            r_popped <= rsp.use_rd ? rd_ext[VALUE_W-1:0] : '0;
            r_found  <= rsp.found;
            r_status <= rsp.status;
            r_occ    <= count_ext[OCC_W-1:0];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.popped_value = r_popped;
    assign o_out.found        = r_found;
    assign o_out.status       = r_status;
    assign o_out.occupancy    = r_occ;

    // A new operation is taken only when the waiting result leaves
    a_ready_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.ready && r_out_valid) |-> o_out.ready)
        else $error("input taken while a result is stalled");

    // A result is never loaded over one that has not transferred
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp.load && r_out_valid) |-> o_out.ready)
        else $error("result overwritten before transfer");

    // The element count stays within the ring
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count_next <= CW'(DEPTH))
        else $error("element count beyond depth");

    // A found flag comes only with an ok status and no popped element
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_found) |-> (r_status == STATUS_OK && r_popped == '0))
        else $error("found flag with error status or popped data");

endmodule

`default_nettype wire

[tb/deq_checker.sv]
// Result checker for the double-ended queue: predicts every result and compares it.
// Depends on deq_pkg and on the deq_in_if / deq_out_if channel interfaces.

module deq_checker #(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    deq_in_if    i_in_mon,
    deq_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    import deq_pkg::*;

    typedef struct {
        logic [VALUE_W-1:0]  popped_value;
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } t_deq_result;

    // Shadow copy of the ring store, head slot and element count
    logic [VALUE_W-1:0] ring_mem [DEPTH];
    int                 front_idx;
    int                 fill_level;

    t_deq_result        result_q [$];
    int                 mismatch_count = 0;

    // Apply one operation to the shadow deque and return the result it gives
    function automatic t_deq_result apply_deque_op(input logic [KIND_W-1:0]  kind,
                                                   input logic [VALUE_W-1:0] value);
        t_deq_result res;
        int          pos;
        res.popped_value = '0;
        res.found        = 1'b0;
        res.status       = STATUS_OK;
        case (kind)
            KIND_PUSH_FRONT: begin
                if (fill_level >= DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    front_idx           = (front_idx + DEPTH - 1) % DEPTH;
                    ring_mem[front_idx] = value;
                    fill_level++;
                end
            end
            KIND_PUSH_BACK: begin
                if (fill_level >= DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    ring_mem[(front_idx + fill_level) % DEPTH] = value;
                    fill_level++;
                end
            end
            KIND_POP_FRONT: begin
                if (fill_level == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.popped_value = ring_mem[front_idx];
                    front_idx        = (front_idx + 1) % DEPTH;
                    fill_level--;
                end
            end
            KIND_POP_BACK: begin
                if (fill_level == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.popped_value = ring_mem[(front_idx + fill_level - 1) % DEPTH];
                    fill_level--;
                end
            end
            KIND_QUERY: begin
                if (fill_level == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    for (pos = 0; pos < fill_level; pos++) begin
                        if (ring_mem[(front_idx + pos) % DEPTH] == value)
                            res.found = 1'b1;
                    end
                end
            end
            default: ;  // unused codes leave the deque alone
        endcase
        res.occupancy = fill_level[OCC_W-1:0];
        return res;
    endfunction

    // Compare one result field and count a mismatch
    task automatic check_field(input string              field_name,
                               input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field_name, want, got);
            mismatch_count++;
        end
    endtask

    // Retire result transfers against the oldest prediction, then predict new input
    always @(posedge i_clk) begin
        t_deq_result want;
        if (!i_rst_n) begin
            front_idx  = 0;
            fill_level = 0;
            result_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h %b %0d %0d",
                             $time, i_out_mon.popped_value, i_out_mon.found,
                             i_out_mon.status, i_out_mon.occupancy);
                    mismatch_count++;
                end else begin
                    want = result_q.pop_front();
                    check_field("popped_value", want.popped_value, i_out_mon.popped_value);
                    check_field("found", VALUE_W'(want.found), VALUE_W'(i_out_mon.found));
                    check_field("status", VALUE_W'(want.status), VALUE_W'(i_out_mon.status));
                    check_field("occupancy", VALUE_W'(want.occupancy),
                                VALUE_W'(i_out_mon.occupancy));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                result_q.push_back(apply_deque_op(i_in_mon.kind, i_in_mon.value));
        end
        o_fail_count <= mismatch_count;
        o_pending    <= result_q.size();
    end

endmodule

[tb/tb_double_ended_queue_with_search.sv]
// Top of the double-ended queue testbench: clock, reset, stimulus and verdict.
// Depends on deq_pkg, the channel interfaces, the queue RTL and deq_checker.

module tb_double_ended_queue_with_search;

    import deq_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int DEPTH          = 16;
    localparam int RANDOM_OPS     = 1350;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 2 * DEPTH;
    localparam int STALL_CYCLES   = 300;

    // Codes outside the operation set; the block answers them without change
    localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

    typedef enum int {
        FILL_BIAS,
        DRAIN_BIAS,
        MIXED
    } t_phase;

    logic               i_clk;
    logic               i_rst_n;
    int                 fail_count;
    int                 pending;
    bit                 tx_steady;
    logic [VALUE_W-1:0] push_hist [DEPTH];
    int                 hist_wr;

    deq_in_if  in_ch ();
    deq_out_if out_ch ();

    double_ended_queue_with_search #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    deq_checker #(
        .DEPTH (DEPTH)
    ) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Element values: the extremes now and then, otherwise any 32-bit pattern
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // Search values: half from recent pushes so that hits are common
    function automatic logic [VALUE_W-1:0] pick_search_value();
        if ($urandom_range(0, 1))
            return push_hist[$urandom_range(0, DEPTH - 1)];
        return pick_value();
    endfunction

    function automatic logic [KIND_W-1:0] draw_kind(input t_phase mode);
        int roll;
        int push_pct;
        int pop_pct;
        push_pct = (mode == FILL_BIAS) ? 70 : (mode == DRAIN_BIAS) ? 15 : 40;
        pop_pct  = (mode == FILL_BIAS) ? 12 : (mode == DRAIN_BIAS) ? 65 : 35;
        roll     = $urandom_range(0, 99);
        if (roll < 3)
            return KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        if (roll < push_pct + pop_pct)
            return $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
        return KIND_QUERY;
    endfunction

    // Offer one operation after a random gap and hold it until the transfer
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
            push_hist[hist_wr] = value;
            hist_wr            = (hist_wr + 1) % DEPTH;
        end
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_drained();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // Stimulus: reset, directed corner cases, then random phases
    initial begin
        t_phase             mode;
        int                 sent;
        int                 phase_len;
        int                 phase_no;
        logic [KIND_W-1:0]  kind;
        in_ch.valid <= 1'b0;
        in_ch.kind  <= KIND_PUSH_FRONT;
        in_ch.value <= '0;
        i_rst_n     <= 1'b0;
        tx_steady   = 1'b0;
        hist_wr     = 0;
        foreach (push_hist[idx]) push_hist[idx] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Errors on the empty queue and an unused code
        send_op(KIND_POP_FRONT, '1);
        send_op(KIND_POP_BACK, '0);
        send_op(KIND_QUERY, '0);
        send_op(KIND_UNUSED_LAST, 32'hDEAD_BEEF);

        // Extremes at both ends, a hit at each end and a miss
        send_op(KIND_PUSH_BACK, '0);
        send_op(KIND_PUSH_FRONT, '1);
        send_op(KIND_QUERY, '1);
        send_op(KIND_QUERY, 32'h0000_0001);
        send_op(KIND_QUERY, '0);
        send_op(KIND_POP_FRONT, '0);

        // Pop the only element from the back, then from the front
        send_op(KIND_POP_BACK, '1);
        send_op(KIND_PUSH_FRONT, 32'h8000_0000);
        send_op(KIND_POP_FRONT, '0);

        // Random phases; the first one fills the queue past full
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_OPS) begin
            mode      = (phase_no == 0) ? FILL_BIAS : t_phase'($urandom_range(0, 2));
            phase_len = (phase_no == 0) ? 60 : $urandom_range(40, 80);
            tx_steady = (phase_no % 4 == 3);
            if (phase_no % 7 == 5)
                wait_drained();
            repeat (phase_len) begin
                kind = draw_kind(mode);
                send_op(kind, (kind == KIND_QUERY) ? pick_search_value() : pick_value());
                if (kind <= KIND_QUERY)
                    sent++;
            end
            phase_no++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending != 0)
            $display("%0t: %0d results outstanding, expected 0", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Result side: random stalls, steady stretches and two long hold-offs
    initial begin
        int gap;
        int taken;
        out_ch.ready <= 1'b0;
        taken = 0;
        @(posedge i_clk);
        forever begin
            gap = ((taken / 64) % 3 == 1) ? 0 : $urandom_range(0, 6);
            if (taken == 400 || taken == 1000)
                gap = STALL_CYCLES;
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            taken++;
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/deq_pkg.sv
hw/rtl/deq_in_if.sv
hw/rtl/deq_out_if.sv
hw/rtl/deq_store.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue_with_search.sv
tb/deq_checker.sv
tb/tb_double_ended_queue_with_search.sv
